/* design/pidpi_pkg.sv */
// ----------------------------------------------------------------------------
// pidpi_pkg
// Shared types, constants and helpers of the PID controller.
// ----------------------------------------------------------------------------
package pidpi_pkg;

	localparam int INCREMENTAL_MODE_DEF = 0;
	localparam int FRACTION_BITS_DEF    = 16;

	localparam int MAG_W  = 34;
	localparam int CFG_AW = 5;
	localparam int ITEM_W = 96;

	typedef logic signed [31:0]       word_t;
	typedef logic signed [34:0]       wide_t;
	typedef logic signed [MAG_W-1:0]  mag_t;

	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam logic [16:0] UNITY_Q16 = 17'h1_0000;

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_OUT_FLOOR,
		REG_OUT_CEIL,
		REG_ACC_FLOOR,
		REG_ACC_CEIL,
		REG_DERIV_SMOOTH
	} reg_idx_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [1:0] {
		SH_FRAC,
		SH_FRAC1,
		SH_Q16
	} sh_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_TRAP,
		ST_LIMIT,
		ST_DIV,
		ST_FILT,
		ST_MP,
		ST_MI,
		ST_MD,
		ST_SAT,
		ST_DONE
	} state_t;

	typedef struct packed {
		word_t       gain_p;
		word_t       gain_i;
		word_t       gain_d;
		word_t       output_floor;
		word_t       output_ceiling;
		word_t       accum_floor;
		word_t       accum_ceiling;
		logic [16:0] deriv_smoothing;
	} cfg_t;

	function automatic word_t sat32(input wide_t v);
		word_t r;
		if (v > wide_t'(WORD_MAX)) r = WORD_MAX;
		else if (v < wide_t'(WORD_MIN)) r = WORD_MIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic word_t clamp(input word_t v, input word_t lo, input word_t hi);
		word_t r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	function automatic mag_t ext(input word_t v);
		return {{(MAG_W-32){v[31]}}, v};
	endfunction

	function automatic wide_t wext(input word_t v);
		return {{3{v[31]}}, v};
	endfunction

endpackage

/* design/pidpi_cfg.sv */
// ----------------------------------------------------------------------------
// pidpi_cfg
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module pidpi_cfg
	import pidpi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= '0;
			cfg_q.gain_i          <= '0;
			cfg_q.gain_d          <= '0;
			cfg_q.output_floor    <= WORD_MIN;
			cfg_q.output_ceiling  <= WORD_MAX;
			cfg_q.accum_floor     <= WORD_MIN;
			cfg_q.accum_ceiling   <= WORD_MAX;
			cfg_q.deriv_smoothing <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:       cfg_q.gain_p          <= pwdata;
				REG_GAIN_I:       cfg_q.gain_i          <= pwdata;
				REG_GAIN_D:       cfg_q.gain_d          <= pwdata;
				REG_OUT_FLOOR:    cfg_q.output_floor    <= pwdata;
				REG_OUT_CEIL:     cfg_q.output_ceiling  <= pwdata;
				REG_ACC_FLOOR:    cfg_q.accum_floor     <= pwdata;
				REG_ACC_CEIL:     cfg_q.accum_ceiling   <= pwdata;
				REG_DERIV_SMOOTH: cfg_q.deriv_smoothing <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_P:       prdata = cfg_q.gain_p;
			REG_GAIN_I:       prdata = cfg_q.gain_i;
			REG_GAIN_D:       prdata = cfg_q.gain_d;
			REG_OUT_FLOOR:    prdata = cfg_q.output_floor;
			REG_OUT_CEIL:     prdata = cfg_q.output_ceiling;
			REG_ACC_FLOOR:    prdata = cfg_q.accum_floor;
			REG_ACC_CEIL:     prdata = cfg_q.accum_ceiling;
			REG_DERIV_SMOOTH: prdata = {15'd0, cfg_q.deriv_smoothing};
			default:          prdata = '0;
		endcase
	end

endmodule

/* design/pidpi_unit.sv */
// ----------------------------------------------------------------------------
// pidpi_unit
// Bit-serial signed multiply (shifted, saturated) and divide (scaled,
// saturated) unit shared by all product and quotient terms.
// ----------------------------------------------------------------------------
module pidpi_unit
	import pidpi_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  op_t   op,
	input  sh_t   sh,
	input  mag_t  a,
	input  mag_t  b,
	output logic  done,
	output word_t res
);

	localparam int DW = MAG_W + FRACTION_BITS;
	localparam int PW = 2 * MAG_W;
	localparam int RW = (PW > DW) ? PW : DW;
	localparam int CW = $clog2(DW + 1);

	logic              busy_q, pend_q, done_q;
	logic [CW-1:0]     cnt_q;
	op_t               op_q;
	sh_t               sh_q;
	logic              neg_q;
	logic [MAG_W-1:0]  mcand_q, hi_q, lo_q, rem_q;
	logic [DW-1:0]     dvd_q, quo_q;
	word_t             res_q;

	logic [MAG_W-1:0]  a_mag, b_mag;
	logic [MAG_W:0]    msum, dtrial;
	logic              dfit;
	logic [CW-1:0]     last;
	logic [PW-1:0]     full;
	logic [PW-1:0]     shifted;
	logic [RW-1:0]     mag_sel;
	logic [31:0]       lim, mag_c;

	assign a_mag  = a[MAG_W-1] ? MAG_W'(-a) : a;
	assign b_mag  = b[MAG_W-1] ? MAG_W'(-b) : b;
	assign msum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
	assign dtrial = {rem_q, dvd_q[DW-1]};
	assign dfit   = dtrial >= {1'b0, mcand_q};
	assign last   = (op_q == OP_MUL) ? CW'(MAG_W - 1) : CW'(DW - 1);
	assign full   = {hi_q, lo_q};

	always_comb begin
		case (sh_q)
			SH_FRAC:  shifted = full >> FRACTION_BITS;
			SH_FRAC1: shifted = full >> (FRACTION_BITS + 1);
			SH_Q16:   shifted = full >> 16;
			default:  shifted = full;
		endcase
		mag_sel = (op_q == OP_MUL) ? RW'(shifted) : RW'(quo_q);
		lim     = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		mag_c   = (mag_sel > RW'(lim)) ? lim : mag_sel[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= pend_q;
			pend_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					pend_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q    <= op;
			sh_q    <= sh;
			neg_q   <= a[MAG_W-1] ^ ((op == OP_MUL) & b[MAG_W-1]);
			mcand_q <= (op == OP_MUL) ? a_mag : b_mag;
			hi_q    <= '0;
			lo_q    <= b_mag;
			rem_q   <= '0;
			dvd_q   <= {a_mag, {FRACTION_BITS{1'b0}}};
			quo_q   <= '0;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				hi_q <= msum[MAG_W:1];
				lo_q <= {msum[0], lo_q[MAG_W-1:1]};
			end else begin
				rem_q <= dfit ? MAG_W'(dtrial - {1'b0, mcand_q}) : dtrial[MAG_W-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
				quo_q <= {quo_q[DW-2:0], dfit};
			end
		end
		if (pend_q) res_q <= neg_q ? -mag_c : mag_c;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* design/pid_controller_position_incremental.sv */
// ----------------------------------------------------------------------------
// pid_controller_position_incremental
// PID controller in signed fixed point, positional or incremental by build.
// ----------------------------------------------------------------------------
// Every multiply and the time-step divide run on one bit-serial shared unit.
// Positional item: three to six unit operations, the fewest without integral
// and derivative, the most with filtering; an incremental item skips the
// derivative multiply on its first step.
// One item at a time; the next is taken once the result is in the output
// register. Reset clears controller state and loads register reset values.
module pid_controller_position_incremental
	import pidpi_pkg::*;
#(
	parameter int INCREMENTAL_MODE = INCREMENTAL_MODE_DEF,
	parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ITEM_W-1:0] s_tdata,  // target_value, measured_value, time_step
	input  logic              s_tuser,  // clear_state
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ITEM_W-1:0] m_tdata,  // drive_value, error_now, accum_now
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam bit INC = (INCREMENTAL_MODE != 0);

	cfg_t   cfg;
	state_t state_q, state_nx;

	word_t       tgt_q, meas_q, e_q, d_q, x_q;
	logic [31:0] dt_q;
	wide_t       sum_q;
	word_t       acc_q, pe_q, oe_q, pd_q;
	logic        first_q, wait_q, out_valid_q;
	logic [ITEM_W-1:0] out_data_q;

	logic   u_start, u_done;
	op_t    u_op;
	sh_t    u_sh;
	mag_t   u_a, u_b;
	word_t  u_res;

	logic        active, accept, free, unit_st;
	logic [16:0] coef;
	word_t       drv, acc_new;

	pidpi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidpi_unit #(.FRACTION_BITS(FRACTION_BITS)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.op     (u_op),
		.sh     (u_sh),
		.a      (u_a),
		.b      (u_b),
		.done   (u_done),
		.res    (u_res)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign active   = !first_q && (dt_q != '0);
	assign free     = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign drv      = clamp(x_q, cfg.output_floor, cfg.output_ceiling);
	assign acc_new  = !INC ? acc_q : (first_q ? x_q : drv);
	assign coef     = UNITY_Q16 -
		((cfg.deriv_smoothing > UNITY_Q16) ? UNITY_Q16 : cfg.deriv_smoothing);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_nx = ST_ERR;
			ST_ERR:   state_nx = INC ? ST_MP : (active ? ST_TRAP : ST_LIMIT);
			ST_TRAP:  if (u_done) state_nx = ST_LIMIT;
			ST_LIMIT: state_nx = active ? ST_DIV : ST_MP;
			ST_DIV:   if (u_done) state_nx = (cfg.deriv_smoothing != '0) ? ST_FILT : ST_MP;
			ST_FILT:  if (u_done) state_nx = ST_MP;
			ST_MP:    if (u_done) state_nx = ST_MI;
			ST_MI:    if (u_done) state_nx = (INC && first_q) ? ST_SAT : ST_MD;
			ST_MD:    if (u_done) state_nx = ST_SAT;
			ST_SAT:   state_nx = ST_DONE;
			ST_DONE:  if (free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		unit_st = 1'b0;
		u_op    = OP_MUL;
		u_sh    = SH_FRAC;
		u_a     = '0;
		u_b     = '0;
		case (state_q)
			ST_TRAP: begin
				unit_st = 1'b1;
				u_sh    = SH_FRAC1;
				u_a     = ext(e_q) + ext(pe_q);
				u_b     = MAG_W'(dt_q);
			end
			ST_DIV: begin
				unit_st = 1'b1;
				u_op    = OP_DIV;
				u_a     = ext(e_q) - ext(pe_q);
				u_b     = MAG_W'(dt_q);
			end
			ST_FILT: begin
				unit_st = 1'b1;
				u_sh    = SH_Q16;
				u_a     = ext(d_q) - ext(pd_q);
				u_b     = MAG_W'(coef);
			end
			ST_MP: begin
				unit_st = 1'b1;
				u_a     = ext(cfg.gain_p);
				u_b     = (INC && !first_q) ? ext(e_q) - ext(pe_q) : ext(e_q);
			end
			ST_MI: begin
				unit_st = 1'b1;
				u_a     = ext(cfg.gain_i);
				u_b     = INC ? ext(e_q) : ext(acc_q);
			end
			ST_MD: begin
				unit_st = 1'b1;
				u_a     = ext(cfg.gain_d);
				if (!INC) u_b = ext(d_q);
				else if (dt_q != '0) u_b = ext(e_q) - (ext(pe_q) <<< 1) + ext(oe_q);
				else u_b = '0;
			end
			default: ;
		endcase
		u_start = unit_st && !wait_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			pe_q        <= '0;
			oe_q        <= '0;
			pd_q        <= '0;
			first_q     <= 1'b1;
		end else begin
			state_q <= state_nx;
			if (u_start) wait_q <= 1'b1;
			else if (u_done) wait_q <= 1'b0;
			if (m_tready && !(state_q == ST_DONE && free)) out_valid_q <= 1'b0;
			if (accept && s_tuser) begin
				acc_q   <= '0;
				pe_q    <= '0;
				oe_q    <= '0;
				pd_q    <= '0;
				first_q <= 1'b1;
			end
			if (state_q == ST_TRAP && u_done) acc_q <= sat32(wext(acc_q) + wext(u_res));
			if (state_q == ST_LIMIT) acc_q <= clamp(acc_q, cfg.accum_floor, cfg.accum_ceiling);
			if (state_q == ST_DONE && free) begin
				out_valid_q <= 1'b1;
				pe_q        <= e_q;
				first_q     <= 1'b0;
				if (INC) begin
					acc_q <= acc_new;
					oe_q  <= pe_q;
				end else begin
					pd_q <= d_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q  <= s_tdata[31:0];
			meas_q <= s_tdata[63:32];
			dt_q   <= s_tdata[95:64];
		end
		if (state_q == ST_ERR) e_q <= sat32(wext(tgt_q) - wext(meas_q));
		if (state_q == ST_LIMIT) d_q <= '0;
		if (state_q == ST_DIV && u_done) d_q <= u_res;
		if (state_q == ST_FILT && u_done) d_q <= sat32(wext(pd_q) + wext(u_res));
		if (state_q == ST_MP && u_done) sum_q <= wext(u_res);
		if ((state_q == ST_MI || state_q == ST_MD) && u_done) sum_q <= sum_q + wext(u_res);
		if (state_q == ST_SAT) begin
			if (INC && !first_q)
				x_q <= clamp(sat32(wext(acc_q) + wext(sat32(sum_q))),
					cfg.accum_floor, cfg.accum_ceiling);
			else
				x_q <= sat32(sum_q);
		end
		if (state_q == ST_DONE && free) out_data_q <= {acc_new, e_q, drv};
	end

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> wait_q)
		else $error("unit result without a pending operation");

	a_idle_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !wait_q)
		else $error("input ready while unit operation pending");

	a_first_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && free) |=> (!first_q && out_valid_q))
		else $error("finished item left first-step flag or output slot wrong");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		u_start |=> !u_done)
		else $error("unit finished right after start");

endmodule
